### src/assert_macros.svh
// Assertion macros shared by the serializer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### src/coap_ms_pkg.sv
package coap_ms_pkg;

    localparam int unsigned MAX_TOKEN_BYTES = 8;
    localparam int unsigned MAX_RESULTS     = 5;
    localparam int unsigned CNT_W           = $clog2(MAX_RESULTS + 1);
    localparam int unsigned IDX_W           = $clog2(MAX_RESULTS);
    localparam logic [15:0] CAPACITY_RESET  = 16'd1024;
    localparam logic [7:0]  PAYLOAD_MARKER  = 8'hFF;
    localparam logic [1:0]  COAP_VERSION    = 2'd1;
    localparam logic [15:0] EXT1_BASE       = 16'd13;
    localparam logic [15:0] EXT2_BASE       = 16'd269;

    localparam logic [2:0] OP_START       = 3'd0;
    localparam logic [2:0] OP_TOKEN_BYTE  = 3'd1;
    localparam logic [2:0] OP_OPT_START   = 3'd2;
    localparam logic [2:0] OP_OPT_BYTE    = 3'd3;
    localparam logic [2:0] OP_PAYLOAD     = 3'd4;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_SPACE  = 3'd1,
        ST_EMPTY_MSG = 3'd2,
        ST_OPT_ORDER = 3'd3,
        ST_SEQUENCE  = 3'd4
    } status_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [1:0]  message_type;
        logic [7:0]  message_code;
        logic [15:0] msg_id;
        logic [3:0]  token_length;
        logic [15:0] option_number;
        logic [15:0] option_length;
        logic [7:0]  data_byte;
    } item_t;

    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [CNT_W-1:0]            count;
        logic                        byte_valid;
        status_t                     status;
    } res_set_t;

    // Number of extension bytes that an option delta or length needs.
    function automatic logic [1:0] ext_size(input logic [15:0] v);
        logic [1:0] n;
        if (v >= EXT2_BASE) begin
            n = 2'd2;
        end
        else if (v >= EXT1_BASE) begin
            n = 2'd1;
        end
        else begin
            n = 2'd0;
        end
        return n;
    endfunction

    function automatic logic [3:0] nibble_of(input logic [15:0] v);
        logic [3:0] n;
        if (v >= EXT2_BASE) begin
            n = 4'd14;
        end
        else if (v >= EXT1_BASE) begin
            n = 4'd13;
        end
        else begin
            n = v[3:0];
        end
        return n;
    endfunction

    // Extension bytes in sending order; entry 0 goes out first.
    function automatic logic [1:0][7:0] ext_bytes(input logic [15:0] v);
        logic [1:0][7:0] b;
        logic [15:0]     e2;
        logic [15:0]     e1;
        e2 = v - EXT2_BASE;
        e1 = v - EXT1_BASE;
        b  = '0;
        if (v >= EXT2_BASE) begin
            b[0] = e2[15:8];
            b[1] = e2[7:0];
        end
        else begin
            b[0] = e1[7:0];
        end
        return b;
    endfunction

endpackage

### src/coap_ms_encoder.sv
`include "assert_macros.svh"

module coap_ms_encoder #(
    parameter int unsigned MAX_TOKEN_BYTES = coap_ms_pkg::MAX_TOKEN_BYTES
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [15:0]           cfg_wdata,
    input  logic                  consume,
    input  coap_ms_pkg::item_t    item,
    output coap_ms_pkg::res_set_t res
);

    logic [15:0] capacity_reg;
    logic [15:0] used_reg,       used_next;
    logic [15:0] prev_num_reg,   prev_num_next;
    logic        marker_reg,     marker_next;
    logic        empty_reg,      empty_next;
    logic        started_reg,    started_next;
    logic [3:0]  token_left_reg, token_left_next;
    logic [15:0] opt_left_reg,   opt_left_next;

    logic [15:0]     room;
    logic [15:0]     delta;
    logic [1:0]      dn;
    logic [1:0]      ln;
    logic [16:0]     need;
    logic [16:0]     hdr_need;
    logic [1:0][7:0] dext;
    logic [1:0][7:0] lext;

    assign room     = (capacity_reg > used_reg) ? (capacity_reg - used_reg) : 16'd0;
    assign delta    = item.option_number - prev_num_reg;
    assign dn       = coap_ms_pkg::ext_size(delta);
    assign ln       = coap_ms_pkg::ext_size(item.option_length);
    assign dext     = coap_ms_pkg::ext_bytes(delta);
    assign lext     = coap_ms_pkg::ext_bytes(item.option_length);
    assign need     = 17'd1 + {15'd0, dn} + {15'd0, ln} + {1'b0, item.option_length};
    assign hdr_need = 17'd4 + {13'd0, item.token_length};

    always_comb
    begin
        used_next       = used_reg;
        prev_num_next   = prev_num_reg;
        marker_next     = marker_reg;
        empty_next      = empty_reg;
        started_next    = started_reg;
        token_left_next = token_left_reg;
        opt_left_next   = opt_left_reg;
        res             = '0;
        res.count       = coap_ms_pkg::CNT_W'(1);
        res.status      = coap_ms_pkg::ST_OK;

        if (item.operation == coap_ms_pkg::OP_START) begin
            used_next       = '0;
            prev_num_next   = '0;
            marker_next     = 1'b0;
            token_left_next = '0;
            opt_left_next   = '0;
            started_next    = 1'b0;
            empty_next      = (item.message_code == 8'd0);
            if (item.token_length > 4'(MAX_TOKEN_BYTES)) begin
                res.status = coap_ms_pkg::ST_SEQUENCE;
            end
            else if ((item.message_code == 8'd0) && (item.token_length != 4'd0)) begin
                res.status = coap_ms_pkg::ST_EMPTY_MSG;
            end
            else if ({1'b0, capacity_reg} < hdr_need) begin
                res.status = coap_ms_pkg::ST_NO_SPACE;
            end
            else begin
                res.byte_valid  = 1'b1;
                res.count       = coap_ms_pkg::CNT_W'(4);
                res.bytes[0]    = {coap_ms_pkg::COAP_VERSION, item.message_type,
                                   item.token_length};
                res.bytes[1]    = item.message_code;
                res.bytes[2]    = item.msg_id[15:8];
                res.bytes[3]    = item.msg_id[7:0];
                used_next       = 16'd4;
                token_left_next = item.token_length;
                started_next    = 1'b1;
            end
        end
        else if (!started_reg) begin
            res.status = coap_ms_pkg::ST_SEQUENCE;
        end
        else begin
            unique case (item.operation)
                coap_ms_pkg::OP_TOKEN_BYTE:
                begin
                    if (token_left_reg == 4'd0) begin
                        res.status = coap_ms_pkg::ST_SEQUENCE;
                    end
                    else begin
                        token_left_next = token_left_reg - 4'd1;
                        if (room == 16'd0) begin
                            res.status = coap_ms_pkg::ST_NO_SPACE;
                        end
                        else begin
                            used_next      = used_reg + 16'd1;
                            res.byte_valid = 1'b1;
                            res.bytes[0]   = item.data_byte;
                        end
                    end
                end
                coap_ms_pkg::OP_OPT_START:
                begin
                    if ((token_left_reg != 4'd0) || (opt_left_reg != 16'd0) || marker_reg) begin
                        res.status = coap_ms_pkg::ST_SEQUENCE;
                    end
                    else if (empty_reg) begin
                        started_next = 1'b0;
                        res.status   = coap_ms_pkg::ST_EMPTY_MSG;
                    end
                    else if (item.option_number < prev_num_reg) begin
                        started_next = 1'b0;
                        res.status   = coap_ms_pkg::ST_OPT_ORDER;
                    end
                    else if (need > {1'b0, room}) begin
                        started_next = 1'b0;
                        res.status   = coap_ms_pkg::ST_NO_SPACE;
                    end
                    else begin
                        res.byte_valid = 1'b1;
                        res.count      = coap_ms_pkg::CNT_W'(3'd1 + {1'b0, dn} + {1'b0, ln});
                        res.bytes[0]   = {coap_ms_pkg::nibble_of(delta),
                                          coap_ms_pkg::nibble_of(item.option_length)};
                        unique case (dn)
                            2'd0:
                            begin
                                res.bytes[1] = lext[0];
                                res.bytes[2] = lext[1];
                            end
                            2'd1:
                            begin
                                res.bytes[1] = dext[0];
                                res.bytes[2] = lext[0];
                                res.bytes[3] = lext[1];
                            end
                            default:
                            begin
                                res.bytes[1] = dext[0];
                                res.bytes[2] = dext[1];
                                res.bytes[3] = lext[0];
                                res.bytes[4] = lext[1];
                            end
                        endcase
                        used_next     = used_reg + 16'(res.count);
                        prev_num_next = item.option_number;
                        opt_left_next = item.option_length;
                    end
                end
                coap_ms_pkg::OP_OPT_BYTE:
                begin
                    if (opt_left_reg == 16'd0) begin
                        res.status = coap_ms_pkg::ST_SEQUENCE;
                    end
                    else begin
                        opt_left_next = opt_left_reg - 16'd1;
                        if (room == 16'd0) begin
                            res.status = coap_ms_pkg::ST_NO_SPACE;
                        end
                        else begin
                            used_next      = used_reg + 16'd1;
                            res.byte_valid = 1'b1;
                            res.bytes[0]   = item.data_byte;
                        end
                    end
                end
                coap_ms_pkg::OP_PAYLOAD:
                begin
                    if ((token_left_reg != 4'd0) || (opt_left_reg != 16'd0)) begin
                        res.status = coap_ms_pkg::ST_SEQUENCE;
                    end
                    else if (!marker_reg) begin
                        if (room < 16'd2) begin
                            res.status = coap_ms_pkg::ST_NO_SPACE;
                        end
                        else begin
                            res.byte_valid = 1'b1;
                            res.count      = coap_ms_pkg::CNT_W'(2);
                            res.bytes[0]   = coap_ms_pkg::PAYLOAD_MARKER;
                            res.bytes[1]   = item.data_byte;
                            used_next      = used_reg + 16'd2;
                            marker_next    = 1'b1;
                        end
                    end
                    else if (room == 16'd0) begin
                        res.status = coap_ms_pkg::ST_NO_SPACE;
                    end
                    else begin
                        used_next      = used_reg + 16'd1;
                        res.byte_valid = 1'b1;
                        res.bytes[0]   = item.data_byte;
                    end
                end
                default:
                begin
                    res.status = coap_ms_pkg::ST_SEQUENCE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            capacity_reg   <= coap_ms_pkg::CAPACITY_RESET;
            used_reg       <= '0;
            prev_num_reg   <= '0;
            marker_reg     <= 1'b0;
            empty_reg      <= 1'b0;
            started_reg    <= 1'b0;
            token_left_reg <= '0;
            opt_left_reg   <= '0;
        end
        else begin
            if (cfg_we) begin
                capacity_reg <= cfg_wdata;
            end
            if (consume) begin
                used_reg       <= used_next;
                prev_num_reg   <= prev_num_next;
                marker_reg     <= marker_next;
                empty_reg      <= empty_next;
                started_reg    <= started_next;
                token_left_reg <= token_left_next;
                opt_left_reg   <= opt_left_next;
            end
        end
    end

    // A header that was sent leaves a started message with exactly four bytes counted.
    `ASSERT_NEXT(a_start_header, clk, rst_n,
        consume && (item.operation == coap_ms_pkg::OP_START) && res.byte_valid,
        started_reg && (used_reg == 16'd4))

    // Every failure other than a start leaves the used byte count and the previous option number unchanged.
    `ASSERT_NEXT(a_fail_no_bytes, clk, rst_n,
        consume && !res.byte_valid && (item.operation != coap_ms_pkg::OP_START),
        $stable(used_reg) && $stable(prev_num_reg))

endmodule

### src/coap_ms_emitter.sv
`include "assert_macros.svh"

module coap_ms_emitter (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  coap_ms_pkg::res_set_t set_in,
    output logic                  set_free,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,
    output logic                  m_tlast,
    output logic [3:0]            m_tuser
);

    coap_ms_pkg::res_set_t               set_reg;
    logic                                set_valid_reg;
    logic [coap_ms_pkg::IDX_W-1:0]       idx_reg;
    logic [coap_ms_pkg::CNT_W-1:0]       last_idx;

    assign last_idx = set_reg.count - coap_ms_pkg::CNT_W'(1);
    assign m_tvalid = set_valid_reg;
    assign m_tdata  = set_reg.bytes[idx_reg];
    assign m_tlast  = (coap_ms_pkg::CNT_W'(idx_reg) == last_idx);
    assign m_tuser  = {set_reg.status, set_reg.byte_valid};
    assign set_free = !set_valid_reg || (m_tready && m_tlast);

    always_ff @(posedge clk)
    begin
        if (load) begin
            set_reg <= set_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            set_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (load) begin
            set_valid_reg <= 1'b1;
            idx_reg       <= '0;
        end
        else if (set_valid_reg && m_tready) begin
            if (m_tlast) begin
                set_valid_reg <= 1'b0;
            end
            else begin
                idx_reg <= idx_reg + coap_ms_pkg::IDX_W'(1);
            end
        end
    end

    // A failure result stands alone and always carries a non-ok status.
    `ASSERT_IMPL(a_fail_single, clk, rst_n,
        set_valid_reg && !set_reg.byte_valid,
        (set_reg.count == coap_ms_pkg::CNT_W'(1)) && (set_reg.status != coap_ms_pkg::ST_OK))

    // The final transaction of a set empties the stage unless a new set is loaded.
    `ASSERT_NEXT(a_last_drains, clk, rst_n,
        set_valid_reg && m_tready && m_tlast && !load,
        !set_valid_reg)

endmodule

### src/coap_message_serializer_top.sv
// CoAP message serializer.
// Items enter on the slave stream (s_tvalid, s_tready, s_tdata, s_tuser); s_tuser
// carries the operation and s_tdata the remaining item fields. Each item produces
// one to five result transactions on the master stream; m_tlast marks the final
// result of an item, m_tuser carries the byte valid flag and the status.
// The user must write the message capacity through cfg_we and cfg_wdata only while the
// block is idle; the block itself does not enforce this. An accepted item is held in
// an input register, encoded combinationally and its result set is loaded into the
// output stage, which hands out one byte per cycle while m_tready is high. An item
// produces one result for token, option data and most payload bytes, two for the
// first payload byte, four for a message header and up to five for an option
// header, so single-byte items stream at one per cycle while m_tready is high.
// Reset clears the message state, empties both stages and restores the capacity
// of 1024 bytes. When the receiver stalls, the output stage holds its byte and the
// input register still takes one further item, after which s_tready falls.
module coap_message_serializer_top #(
    parameter int unsigned MAX_TOKEN_BYTES = coap_ms_pkg::MAX_TOKEN_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // message_type, message_code, msg_id, token_length, option_number,
    // option_length, data_byte, then two unused bits.
    input  logic [71:0] s_tdata,
    // operation.
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_byte.
    output logic [7:0]  m_tdata,
    output logic        m_tlast,
    // byte_valid, status.
    output logic [3:0]  m_tuser
);

    logic                  in_valid_reg;
    coap_ms_pkg::item_t    in_item_reg;
    coap_ms_pkg::res_set_t res;
    logic                  set_free;
    logic                  consume;

    // The held item moves on whenever the output stage can take its result set.
    assign consume  = in_valid_reg && set_free;
    assign s_tready = !in_valid_reg || set_free;

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready) begin
            in_item_reg.operation     <= s_tuser;
            in_item_reg.message_type  <= s_tdata[1:0];
            in_item_reg.message_code  <= s_tdata[9:2];
            in_item_reg.msg_id        <= s_tdata[25:10];
            in_item_reg.token_length  <= s_tdata[29:26];
            in_item_reg.option_number <= s_tdata[45:30];
            in_item_reg.option_length <= s_tdata[61:46];
            in_item_reg.data_byte     <= s_tdata[69:62];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end
        else if (consume) begin
            in_valid_reg <= 1'b0;
        end
    end

    coap_ms_encoder #(
        .MAX_TOKEN_BYTES (MAX_TOKEN_BYTES)
    ) u_encoder (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .consume   (consume),
        .item      (in_item_reg),
        .res       (res)
    );

    coap_ms_emitter u_emitter (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (consume),
        .set_in   (res),
        .set_free (set_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

### bench/coap_message_serializer_top_test.sv
`timescale 1ns / 1ps

module coap_message_serializer_top_test;

    // One result transaction as the master stream should deliver it.
    typedef struct packed {
        logic                 valid;
        logic [7:0]           data;
        logic                 last;
        coap_ms_pkg::status_t status;
    } byte_result_t;

    // Number of consecutive cycles without any transaction before the run is abandoned.
    // It is set well above LONG_HOLD, the long receiver hold-off.
    localparam int QUIET_LIMIT   = 2000;
    localparam int LONG_HOLD     = 300;
    localparam int IDLE_PERCENT  = 6;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = 16'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = 72'd0;
    logic [2:0]  s_tuser = 3'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic [3:0]  m_tuser;

    // Items waiting to be offered; the front one is on the bus while s_tvalid is high.
    coap_ms_pkg::item_t pending_items[$];
    // Message bytes and statuses still owed by the block, oldest first.
    byte_result_t       expected_message_bytes[$];

    // Serializer state as the bench predicts it.
    logic [15:0] capacity = coap_ms_pkg::CAPACITY_RESET;
    logic [15:0] bytes_used = 16'd0;
    logic [15:0] prev_option = 16'd0;
    logic        marker_sent = 1'b0;
    logic        empty_message = 1'b0;
    logic        in_message = 1'b0;
    logic [3:0]  tokens_left = 4'd0;
    logic [15:0] option_left = 16'd0;

    // Controls set by the stimulus process and read by the driver and the monitor.
    logic steady = 1'b0;
    int   stall_requests = 0;

    // Monitor-owned bookkeeping.
    int stall_served = 0;
    int hold_left = 0;

    int failures = 0;
    int items_accepted = 0;
    int results_checked = 0;
    int messages_built = 0;
    int capacity_settings = 1;

    coap_message_serializer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction of the serializer.
    // ------------------------------------------------------------------

    function automatic byte_result_t message_byte(input logic [7:0] b);
        message_byte = '{1'b1, b, 1'b0, coap_ms_pkg::ST_OK};
    endfunction

    // Extension bytes that an option delta or length needs beyond its nibble.
    function automatic int unsigned ext_len(input int unsigned v);
        ext_len = (v >= 269) ? 2 : ((v >= 13) ? 1 : 0);
    endfunction

    function automatic logic [3:0] length_nibble(input int unsigned v);
        length_nibble = (v >= 269) ? 4'd14 : ((v >= 13) ? 4'd13 : v[3:0]);
    endfunction

    // Appends the extension bytes of an option delta or length, high byte first.
    function automatic void add_ext(ref byte_result_t q[$], input int unsigned v);
        logic [15:0] e;
        if (v >= 269) begin
            e = 16'(v - 269);
            q.push_back(message_byte(e[15:8]));
            q.push_back(message_byte(e[7:0]));
        end
        else if (v >= 13) begin
            e = 16'(v - 13);
            q.push_back(message_byte(e[7:0]));
        end
    endfunction

    // Works out the result transactions of one accepted item and advances the
    // predicted message state. An item that produces no message byte yields a
    // single result carrying only its status.
    function automatic void serialize_item(input coap_ms_pkg::item_t it);
        byte_result_t         out[$];
        coap_ms_pkg::status_t st;
        int unsigned          room;
        int unsigned          delta;
        int unsigned          need;
        st = coap_ms_pkg::ST_OK;
        room = (capacity > bytes_used) ? capacity - bytes_used : 0;
        if (it.operation == coap_ms_pkg::OP_START) begin
            bytes_used = 16'd0;
            prev_option = 16'd0;
            marker_sent = 1'b0;
            tokens_left = 4'd0;
            option_left = 16'd0;
            in_message = 1'b0;
            empty_message = (it.message_code == 8'd0);
            if (it.token_length > coap_ms_pkg::MAX_TOKEN_BYTES) begin
                st = coap_ms_pkg::ST_SEQUENCE;
            end
            else if (empty_message && it.token_length != 4'd0) begin
                st = coap_ms_pkg::ST_EMPTY_MSG;
            end
            else if (capacity < 4 + it.token_length) begin
                st = coap_ms_pkg::ST_NO_SPACE;
            end
            else begin
                out.push_back(message_byte({coap_ms_pkg::COAP_VERSION, it.message_type,
                                            it.token_length}));
                out.push_back(message_byte(it.message_code));
                out.push_back(message_byte(it.msg_id[15:8]));
                out.push_back(message_byte(it.msg_id[7:0]));
                bytes_used = 16'd4;
                tokens_left = it.token_length;
                in_message = 1'b1;
            end
        end
        else if (!in_message) begin
            st = coap_ms_pkg::ST_SEQUENCE;
        end
        else begin
            case (it.operation)
                coap_ms_pkg::OP_TOKEN_BYTE:
                begin
                    if (tokens_left == 4'd0) begin
                        st = coap_ms_pkg::ST_SEQUENCE;
                    end
                    else begin
                        // The token count moves on even when the byte is dropped.
                        tokens_left = tokens_left - 4'd1;
                        if (room == 0) begin
                            st = coap_ms_pkg::ST_NO_SPACE;
                        end
                        else begin
                            bytes_used = bytes_used + 16'd1;
                            out.push_back(message_byte(it.data_byte));
                        end
                    end
                end
                coap_ms_pkg::OP_OPT_START:
                begin
                    if (tokens_left != 4'd0 || option_left != 16'd0 || marker_sent) begin
                        st = coap_ms_pkg::ST_SEQUENCE;
                    end
                    else begin
                        if (empty_message) begin
                            st = coap_ms_pkg::ST_EMPTY_MSG;
                        end
                        else if (it.option_number < prev_option) begin
                            st = coap_ms_pkg::ST_OPT_ORDER;
                        end
                        else begin
                            delta = it.option_number - prev_option;
                            need = 1 + ext_len(delta) + ext_len(it.option_length)
                                   + it.option_length;
                            // The whole option, data included, must fit up front.
                            if (need > room) begin
                                st = coap_ms_pkg::ST_NO_SPACE;
                            end
                            else begin
                                out.push_back(message_byte({length_nibble(delta),
                                                            length_nibble(it.option_length)}));
                                add_ext(out, delta);
                                add_ext(out, it.option_length);
                                bytes_used = bytes_used + 16'(out.size());
                                prev_option = it.option_number;
                                option_left = it.option_length;
                            end
                        end
                        // A rejected option header abandons the message.
                        if (st != coap_ms_pkg::ST_OK) begin
                            in_message = 1'b0;
                        end
                    end
                end
                coap_ms_pkg::OP_OPT_BYTE:
                begin
                    if (option_left == 16'd0) begin
                        st = coap_ms_pkg::ST_SEQUENCE;
                    end
                    else begin
                        option_left = option_left - 16'd1;
                        if (room == 0) begin
                            st = coap_ms_pkg::ST_NO_SPACE;
                        end
                        else begin
                            bytes_used = bytes_used + 16'd1;
                            out.push_back(message_byte(it.data_byte));
                        end
                    end
                end
                coap_ms_pkg::OP_PAYLOAD:
                begin
                    if (tokens_left != 4'd0 || option_left != 16'd0) begin
                        st = coap_ms_pkg::ST_SEQUENCE;
                    end
                    else if (!marker_sent) begin
                        // The first payload byte needs room for the marker as well.
                        if (room < 2) begin
                            st = coap_ms_pkg::ST_NO_SPACE;
                        end
                        else begin
                            out.push_back(message_byte(coap_ms_pkg::PAYLOAD_MARKER));
                            out.push_back(message_byte(it.data_byte));
                            bytes_used = bytes_used + 16'd2;
                            marker_sent = 1'b1;
                        end
                    end
                    else if (room == 0) begin
                        st = coap_ms_pkg::ST_NO_SPACE;
                    end
                    else begin
                        bytes_used = bytes_used + 16'd1;
                        out.push_back(message_byte(it.data_byte));
                    end
                end
                default:
                begin
                    st = coap_ms_pkg::ST_SEQUENCE;
                end
            endcase
        end
        if (out.size() == 0) begin
            out.push_back('{1'b0, 8'h00, 1'b0, st});
        end
        out[out.size() - 1].last = 1'b1;
        foreach (out[i]) begin
            expected_message_bytes.push_back(out[i]);
        end
    endfunction

    // ------------------------------------------------------------------
    // Item construction. Fields that an operation ignores are filled at
    // random so that every bit of every field is toggled.
    // ------------------------------------------------------------------

    function automatic coap_ms_pkg::item_t random_item();
        coap_ms_pkg::item_t it;
        it.operation = 3'($urandom_range(4));
        it.message_type = 2'($urandom);
        it.message_code = 8'($urandom);
        it.msg_id = 16'($urandom);
        it.token_length = 4'($urandom);
        it.option_number = 16'($urandom);
        it.option_length = 16'($urandom);
        it.data_byte = 8'($urandom);
        random_item = it;
    endfunction

    function automatic coap_ms_pkg::item_t start_item(input logic [1:0] mtype,
                                                      input logic [7:0] code,
                                                      input logic [15:0] id,
                                                      input logic [3:0] tkl);
        coap_ms_pkg::item_t it;
        it = random_item();
        it.operation = coap_ms_pkg::OP_START;
        it.message_type = mtype;
        it.message_code = code;
        it.msg_id = id;
        it.token_length = tkl;
        start_item = it;
    endfunction

    function automatic coap_ms_pkg::item_t option_item(input logic [15:0] num,
                                                       input logic [15:0] len);
        coap_ms_pkg::item_t it;
        it = random_item();
        it.operation = coap_ms_pkg::OP_OPT_START;
        it.option_number = num;
        it.option_length = len;
        option_item = it;
    endfunction

    function automatic coap_ms_pkg::item_t data_item(input logic [2:0] op,
                                                     input logic [7:0] b);
        coap_ms_pkg::item_t it;
        it = random_item();
        it.operation = op;
        it.data_byte = b;
        data_item = it;
    endfunction

    // Queues one message: mostly well formed with random content, sometimes
    // broken by a dropped, repeated or replaced item, and now and then a lone
    // random item instead of a message. Returns the number of items queued.
    function automatic int queue_message();
        coap_ms_pkg::item_t msg[$];
        int unsigned        num;
        int unsigned        d;
        int unsigned        len;
        int unsigned        sent;
        int                 tkl;
        int                 k;
        logic [7:0]         code;
        bit                 truncated;
        if ($urandom_range(99) < 5) begin
            pending_items.push_back(random_item());
            return 1;
        end
        messages_built++;
        code = ($urandom_range(99) < 8) ? 8'd0 : 8'($urandom_range(255, 1));
        tkl = $urandom_range(coap_ms_pkg::MAX_TOKEN_BYTES);
        if (code == 8'd0 && $urandom_range(1) == 0) begin
            tkl = 0;
        end
        msg.push_back(start_item(2'($urandom), code, 16'($urandom), 4'(tkl)));
        for (int i = 0; i < tkl; i++) begin
            msg.push_back(data_item(coap_ms_pkg::OP_TOKEN_BYTE, 8'($urandom)));
        end
        num = 0;
        truncated = 1'b0;
        for (int n = $urandom_range(3); n > 0 && !truncated; n--) begin
            k = $urandom_range(99);
            if (k < 60) begin
                d = $urandom_range(12);
            end
            else if (k < 85) begin
                d = $urandom_range(268, 13);
            end
            else begin
                d = $urandom_range(65535, 269);
            end
            if (d > 65535 - num) begin
                d = 65535 - num;
            end
            num = num + d;
            // Occasionally step backwards to provoke an ordering error.
            if ($urandom_range(99) < 4) begin
                num = $urandom_range(num);
            end
            k = $urandom_range(99);
            if (k < 70) begin
                len = $urandom_range(12);
            end
            else if (k < 92) begin
                len = $urandom_range(20, 13);
            end
            else if (k < 97) begin
                len = $urandom_range(300, 269);
            end
            else begin
                len = $urandom_range(65535);
            end
            // Long option values are cut short and the message ends there.
            sent = (len > 20) ? $urandom_range(3) : len;
            truncated = (sent != len);
            msg.push_back(option_item(16'(num), 16'(len)));
            for (int i = 0; i < sent; i++) begin
                msg.push_back(data_item(coap_ms_pkg::OP_OPT_BYTE, 8'($urandom)));
            end
        end
        if (!truncated) begin
            for (int i = $urandom_range(6); i > 0; i--) begin
                msg.push_back(data_item(coap_ms_pkg::OP_PAYLOAD, 8'($urandom)));
            end
        end
        if (msg.size() > 1 && $urandom_range(99) < 15) begin
            k = $urandom_range(msg.size() - 1);
            case ($urandom_range(2))
                0: msg.delete(k);
                1: msg.insert(k, msg[k]);
                default: msg[k] = random_item();
            endcase
        end
        foreach (msg[i]) begin
            pending_items.push_back(msg[i]);
        end
        return msg.size();
    endfunction

    // ------------------------------------------------------------------
    // Slave-side driver. The front item of the queue is offered; once tvalid
    // is raised it stays up until the transaction completes.
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : sender
        logic               offer;
        coap_ms_pkg::item_t it;
        if (rst_n) begin
            if (s_tvalid && s_tready) begin
                serialize_item(pending_items.pop_front());
                items_accepted++;
            end
            if (s_tvalid && !s_tready) begin
                offer = 1'b1;
            end
            else begin
                offer = (pending_items.size() != 0)
                        && (steady || $urandom_range(99) >= IDLE_PERCENT);
            end
            s_tvalid <= offer;
            if (offer) begin
                it = pending_items[0];
                s_tuser <= it.operation;
                s_tdata <= {2'b00, it.data_byte, it.option_length, it.option_number,
                            it.token_length, it.msg_id, it.message_code, it.message_type};
            end
        end
    end

    // ------------------------------------------------------------------
    // Master-side monitor. Every result transaction is checked against the
    // oldest outstanding prediction. tready drops at random, and on request
    // it is held low for a long stretch so that the block backs up.
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : receiver
        byte_result_t want;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                results_checked++;
                if (expected_message_bytes.size() == 0) begin
                    $error("result with nothing expected: out_byte %0h last %0d user %0h",
                           m_tdata, m_tlast, m_tuser);
                    failures++;
                end
                else begin
                    want = expected_message_bytes.pop_front();
                    if (m_tuser[0] !== want.valid) begin
                        $error("byte_valid: expected %0d, got %0d", want.valid, m_tuser[0]);
                        failures++;
                    end
                    if (m_tdata !== want.data) begin
                        $error("out_byte: expected %0h, got %0h", want.data, m_tdata);
                        failures++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, m_tlast);
                        failures++;
                    end
                    if (m_tuser[3:1] !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser[3:1]);
                        failures++;
                    end
                end
            end
            if (stall_served != stall_requests) begin
                stall_served = stall_requests;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else begin
                m_tready <= steady || $urandom_range(99) >= IDLE_PERCENT;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: ends the run if no transaction happens on either side for
    // too long.
    // ------------------------------------------------------------------

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end
            else begin
                quiet++;
            end
        end
        $error("no transaction for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, expected_message_bytes.size());
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus sequencing.
    // ------------------------------------------------------------------

    // Waits until every queued item has been taken and every predicted result
    // has arrived, then lets the two-stage pipeline settle.
    task automatic wait_quiet();
        @(posedge clk);
        while (pending_items.size() != 0 || s_tvalid || expected_message_bytes.size() != 0) begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // Capacity is only written while the block has nothing in flight.
    task automatic set_capacity(input logic [15:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        capacity = value;
        capacity_settings++;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // One phase at a fixed capacity. The message state deliberately carries
    // over from the previous phase, so a capacity lowered below the bytes
    // already used is met at the start of many phases.
    task automatic run_phase(input logic [15:0] cap, input int items,
                             input bit pressure, input bit no_idle);
        int queued;
        wait_quiet();
        set_capacity(cap);
        if (no_idle) begin
            steady <= 1'b1;
        end
        queued = 0;
        while (queued < items / 2) begin
            queued += queue_message();
        end
        if (pressure) begin
            // Receiver holds off while the sender keeps offering, then the
            // sender waits for every result before carrying on.
            stall_requests <= stall_requests + 1;
            wait_quiet();
        end
        while (queued < items) begin
            queued += queue_message();
        end
        wait_quiet();
        steady <= 1'b0;
    endtask

    initial
    begin : stimulus
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed items at the capacity left by reset.
        pending_items.push_back(data_item(coap_ms_pkg::OP_PAYLOAD, 8'h11)); // nothing open yet
        pending_items.push_back(start_item(2'd0, 8'h01, 16'h0000, 4'd15)); // token too long
        pending_items.push_back(start_item(2'd0, 8'h00, 16'h0000, 4'd1));  // empty with token
        pending_items.push_back(start_item(2'd0, 8'h00, 16'h0000, 4'd0));  // empty header
        pending_items.push_back(option_item(16'd5, 16'd0));         // option in empty message
        pending_items.push_back(start_item(2'd3, 8'hFF, 16'hFFFF, 4'd8));
        pending_items.push_back(option_item(16'd1, 16'd0));         // token bytes pending
        pending_items.push_back(start_item(2'd1, 8'h45, 16'h1234, 4'd1));
        pending_items.push_back(data_item(coap_ms_pkg::OP_TOKEN_BYTE, 8'h00));
        // One token byte too many.
        pending_items.push_back(data_item(coap_ms_pkg::OP_TOKEN_BYTE, 8'hFF));
        // No option data pending.
        pending_items.push_back(data_item(coap_ms_pkg::OP_OPT_BYTE, 8'h5A));
        pending_items.push_back(option_item(16'd12, 16'd1));
        pending_items.push_back(data_item(coap_ms_pkg::OP_OPT_BYTE, 8'hFF));
        pending_items.push_back(option_item(16'd25, 16'd13));       // one-byte extensions
        pending_items.push_back(option_item(16'd30, 16'd0));        // option data pending
        pending_items.push_back(start_item(2'd2, 8'h01, 16'h00FF, 4'd0));
        pending_items.push_back(option_item(16'd268, 16'd268));     // largest one-byte forms
        pending_items.push_back(start_item(2'd2, 8'h01, 16'h0100, 4'd0));
        pending_items.push_back(option_item(16'd269, 16'd300));     // two-byte extensions
        pending_items.push_back(start_item(2'd2, 8'h02, 16'h8000, 4'd0));
        pending_items.push_back(option_item(16'd7, 16'd0));
        pending_items.push_back(option_item(16'd3, 16'd0));         // number goes backwards
        // Message abandoned.
        pending_items.push_back(data_item(coap_ms_pkg::OP_PAYLOAD, 8'h00));
        pending_items.push_back(start_item(2'd1, 8'h03, 16'h0001, 4'd0));
        // Marker plus byte.
        pending_items.push_back(data_item(coap_ms_pkg::OP_PAYLOAD, 8'h00));
        pending_items.push_back(data_item(coap_ms_pkg::OP_PAYLOAD, 8'hFF));
        pending_items.push_back(option_item(16'd40, 16'd0));        // option after payload

        run_phase(16'd65535, 130, 1'b1, 1'b0);
        run_phase(16'd0, 25, 1'b0, 1'b0);
        run_phase(16'd5, 60, 1'b0, 1'b0);
        run_phase(16'd12, 70, 1'b0, 1'b0);
        run_phase(16'd40, 80, 1'b0, 1'b1);
        run_phase(16'd1024, 90, 1'b0, 1'b0);

        wait_quiet();
        repeat (10) @(posedge clk);
        if (expected_message_bytes.size() != 0) begin
            $error("%0d results never arrived", expected_message_bytes.size());
            failures++;
        end
        $display("Run covered %0d items (%0d generated messages) over %0d capacity settings,",
                 items_accepted, messages_built, capacity_settings);
        $display("with %0d result transactions checked and %0d mismatches.",
                 results_checked, failures);
        if (failures == 0) begin
            $display("simulation ok");
        end
        else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
